// File: sv/jpd_pkg.sv
package jpd_pkg;

  // Field widths fixed by the interface
  localparam int IN_W     = 32;
  localparam int OUT_W    = 32;
  localparam int CFG_W    = 31;
  localparam int MARGIN_W = 16;
  localparam int IDX_W    = 3;
  localparam int CDATA_W  = 32;

  // Pipeline shape: multiplier depth and total latency from accept to result
  localparam int MUL_DEPTH  = 3;
  localparam int PIPE_DEPTH = 10;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_STEP_TIME     = 3'd0,
    REG_INV_STEP_TIME = 3'd1,
    REG_TWO_OVER_DT2  = 3'd2,
    REG_POS_GAIN      = 3'd3,
    REG_VEL_GAIN      = 3'd4,
    REG_CLAMP_MARGIN  = 3'd5
  } jpd_reg_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_LOW      = 2'd1,
    STAT_HIGH     = 2'd2,
    STAT_FALLBACK = 2'd3
  } jpd_status_e;

  // Register reset values
  localparam logic [CFG_W-1:0]    RST_STEP_TIME     = 31'd655;
  localparam logic [CFG_W-1:0]    RST_INV_STEP_TIME = 31'd6553600;
  localparam logic [CFG_W-1:0]    RST_TWO_OVER_DT2  = 31'd2147483647;
  localparam logic [CFG_W-1:0]    RST_POS_GAIN      = 31'd6553600;
  localparam logic [CFG_W-1:0]    RST_VEL_GAIN      = 31'd655360;
  localparam logic [MARGIN_W-1:0] RST_CLAMP_MARGIN  = 16'd66;

endpackage

// File: sv/joint_pd_accel_with_limits.sv
// Per-joint PD plus feedforward acceleration with joint-limit clamping.
// Pipeline from start to done: front stage, two 3-stage multiplier passes in
// series, one add stage, two clamp stages.
// Throughput: one item per cycle; busy_o stays low and done_o is a one-cycle strobe.
// Reset clears the valid pipeline and loads the register defaults; no flush pass.
// The receiver cannot stall: each result is on the ports for one cycle only.
module joint_pd_accel_with_limits import jpd_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [IN_W-1:0]  desired_position_i,
  input  logic signed [IN_W-1:0]  desired_velocity_i,
  input  logic signed [IN_W-1:0]  desired_acceleration_i,
  input  logic signed [IN_W-1:0]  measured_position_i,
  input  logic signed [IN_W-1:0]  measured_velocity_i,
  input  logic signed [IN_W-1:0]  position_min_i,
  input  logic signed [IN_W-1:0]  position_max_i,
  input  logic [CFG_W-1:0]        speed_limit_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] accel_command_o,
  output logic signed [OUT_W-1:0] accel_lower_o,
  output logic signed [OUT_W-1:0] accel_upper_o,
  output logic [1:0]              status_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CDATA_W-1:0]      cfg_data_i
);

  localparam int DW = DATA_WIDTH;
  localparam int WW = ((DW > IN_W) ? DW : IN_W) + 2;

  function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      sat_w = hi[DW-1:0];
    end else if (x < lo) begin
      sat_w = lo[DW-1:0];
    end else begin
      sat_w = x[DW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CFG_W-1:0]    step_time_q, inv_step_time_q, two_over_dt2_q;
  logic [CFG_W-1:0]    pos_gain_q, vel_gain_q;
  logic [MARGIN_W-1:0] clamp_margin_q;

  assign cfg_ready_o = 1'b1;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q     <= RST_STEP_TIME;
      inv_step_time_q <= RST_INV_STEP_TIME;
      two_over_dt2_q  <= RST_TWO_OVER_DT2;
      pos_gain_q      <= RST_POS_GAIN;
      vel_gain_q      <= RST_VEL_GAIN;
      clamp_margin_q  <= RST_CLAMP_MARGIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_STEP_TIME:     step_time_q     <= cfg_data_i[CFG_W-1:0];
        REG_INV_STEP_TIME: inv_step_time_q <= cfg_data_i[CFG_W-1:0];
        REG_TWO_OVER_DT2:  two_over_dt2_q  <= cfg_data_i[CFG_W-1:0];
        REG_POS_GAIN:      pos_gain_q      <= cfg_data_i[CFG_W-1:0];
        REG_VEL_GAIN:      vel_gain_q      <= cfg_data_i[CFG_W-1:0];
        REG_CLAMP_MARGIN:  clamp_margin_q  <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Registers at the working width
  logic signed [DW-1:0] dt_s, idt_s, tos_s, kp_s, kd_s, margin_s;

  always_comb begin
    dt_s     = sat_w(WW'($signed({1'b0, step_time_q})));
    idt_s    = sat_w(WW'($signed({1'b0, inv_step_time_q})));
    tos_s    = sat_w(WW'($signed({1'b0, two_over_dt2_q})));
    kp_s     = sat_w(WW'($signed({1'b0, pos_gain_q})));
    kd_s     = sat_w(WW'($signed({1'b0, vel_gain_q})));
    margin_s = sat_w(WW'($signed({1'b0, clamp_margin_q})));
  end

  // ---------------------------------------------------------------------------
  // Valid pipeline
  logic [PIPE_DEPTH-1:0] valid_q;

  assign busy_o = 1'b0;

  // Advance one valid bit per stage alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], start_i && !busy_o};
    end
  end

  assign done_o = valid_q[PIPE_DEPTH-1];

  // ---------------------------------------------------------------------------
  // Stage 1: errors and operands
  logic signed [DW-1:0] dacc1, mvel1, dv1, dp1, pmin_rel1, pmax_rel1, lovel_arg1, hivel_arg1;

  jpd_front #(.DW(DW)) u_front (
    .clk_i                  (clk_i),
    .desired_position_i     (desired_position_i),
    .desired_velocity_i     (desired_velocity_i),
    .desired_acceleration_i (desired_acceleration_i),
    .measured_position_i    (measured_position_i),
    .measured_velocity_i    (measured_velocity_i),
    .position_min_i         (position_min_i),
    .position_max_i         (position_max_i),
    .speed_limit_i          (speed_limit_i),
    .dacc_o                 (dacc1),
    .mvel_o                 (mvel1),
    .dvel_err_o             (dv1),
    .dpos_err_o             (dp1),
    .pmin_rel_o             (pmin_rel1),
    .pmax_rel_o             (pmax_rel1),
    .lovel_arg_o            (lovel_arg1),
    .hivel_arg_o            (hivel_arg1)
  );

  // ---------------------------------------------------------------------------
  // Stages 2-4: first multiplier pass
  logic signed [DW-1:0] kd_dv4, kp_dp4, drift4, kd_mv4, lovel4, hivel4;

  jpd_mul #(.DW(DW)) u_mul_kd_dv (.clk_i(clk_i), .a_i(kd_s), .b_i(dv1), .p_o(kd_dv4));
  jpd_mul #(.DW(DW)) u_mul_kp_dp (.clk_i(clk_i), .a_i(kp_s), .b_i(dp1), .p_o(kp_dp4));
  jpd_mul #(.DW(DW)) u_mul_drift (.clk_i(clk_i), .a_i(dt_s), .b_i(mvel1), .p_o(drift4));
  jpd_mul #(.DW(DW)) u_mul_kd_mv (.clk_i(clk_i), .a_i(kd_s), .b_i(mvel1), .p_o(kd_mv4));
  jpd_mul #(.DW(DW)) u_mul_lovel (.clk_i(clk_i), .a_i(lovel_arg1), .b_i(idt_s), .p_o(lovel4));
  jpd_mul #(.DW(DW)) u_mul_hivel (.clk_i(clk_i), .a_i(hivel_arg1), .b_i(idt_s), .p_o(hivel4));

  // Hold the pass-through terms in step with the multipliers
  logic signed [DW-1:0] dacc_dly_q     [MUL_DEPTH];
  logic signed [DW-1:0] pmin_rel_dly_q [MUL_DEPTH];
  logic signed [DW-1:0] pmax_rel_dly_q [MUL_DEPTH];

  always_ff @(posedge clk_i) begin
    dacc_dly_q[0]     <= dacc1;
    pmin_rel_dly_q[0] <= pmin_rel1;
    pmax_rel_dly_q[0] <= pmax_rel1;
    for (int i = 1; i < MUL_DEPTH; i++) begin
      dacc_dly_q[i]     <= dacc_dly_q[i-1];
      pmin_rel_dly_q[i] <= pmin_rel_dly_q[i-1];
      pmax_rel_dly_q[i] <= pmax_rel_dly_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sum the command, finish the position-bound operands
  logic signed [DW-1:0] cmd_ff;
  logic signed [DW-1:0] cmd5_q, lopos_arg5_q, hipos_arg5_q, lovel5_q, hivel5_q, fb5_q;

  assign cmd_ff = sat_w(WW'(dacc_dly_q[MUL_DEPTH-1]) + WW'(kd_dv4));

  always_ff @(posedge clk_i) begin
    cmd5_q       <= sat_w(WW'(cmd_ff) + WW'(kp_dp4));
    lopos_arg5_q <= sat_w(WW'(pmin_rel_dly_q[MUL_DEPTH-1]) - WW'(drift4));
    hipos_arg5_q <= sat_w(WW'(pmax_rel_dly_q[MUL_DEPTH-1]) - WW'(drift4));
    lovel5_q     <= lovel4;
    hivel5_q     <= hivel4;
    fb5_q        <= sat_w(-WW'(kd_mv4));
  end

  // ---------------------------------------------------------------------------
  // Stages 6-8: second multiplier pass for the position bounds
  logic signed [DW-1:0] lopos8, hipos8;

  jpd_mul #(.DW(DW)) u_mul_lopos (.clk_i(clk_i), .a_i(lopos_arg5_q), .b_i(tos_s), .p_o(lopos8));
  jpd_mul #(.DW(DW)) u_mul_hipos (.clk_i(clk_i), .a_i(hipos_arg5_q), .b_i(tos_s), .p_o(hipos8));

  logic signed [DW-1:0] cmd_dly_q   [MUL_DEPTH];
  logic signed [DW-1:0] lovel_dly_q [MUL_DEPTH];
  logic signed [DW-1:0] hivel_dly_q [MUL_DEPTH];
  logic signed [DW-1:0] fb_dly_q    [MUL_DEPTH];

  always_ff @(posedge clk_i) begin
    cmd_dly_q[0]   <= cmd5_q;
    lovel_dly_q[0] <= lovel5_q;
    hivel_dly_q[0] <= hivel5_q;
    fb_dly_q[0]    <= fb5_q;
    for (int i = 1; i < MUL_DEPTH; i++) begin
      cmd_dly_q[i]   <= cmd_dly_q[i-1];
      lovel_dly_q[i] <= lovel_dly_q[i-1];
      hivel_dly_q[i] <= hivel_dly_q[i-1];
      fb_dly_q[i]    <= fb_dly_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 9-10: bounds and clamp
  jpd_clamp #(.DW(DW)) u_clamp (
    .clk_i           (clk_i),
    .cmd_i           (cmd_dly_q[MUL_DEPTH-1]),
    .fallback_i      (fb_dly_q[MUL_DEPTH-1]),
    .lo_pos_i        (lopos8),
    .lo_vel_i        (lovel_dly_q[MUL_DEPTH-1]),
    .hi_pos_i        (hipos8),
    .hi_vel_i        (hivel_dly_q[MUL_DEPTH-1]),
    .margin_i        (margin_s),
    .accel_command_o (accel_command_o),
    .accel_lower_o   (accel_lower_o),
    .accel_upper_o   (accel_upper_o),
    .status_o        (status_o)
  );

`ifndef SYNTHESIS
  // A result only appears for an item accepted exactly one latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PIPE_DEPTH))
    else $error("result without a matching accepted item");

  // Fallback is only taken on inverted or touching bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FALLBACK)) |->
      ($signed(accel_lower_o) >= $signed(accel_upper_o)))
    else $error("fallback status with ordered bounds");

  // An unclamped command lies between the reported bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_OK)) |->
      (($signed(accel_lower_o) <= $signed(accel_command_o)) &&
       ($signed(accel_command_o) <= $signed(accel_upper_o))))
    else $error("unclamped command outside the bounds");
`endif

endmodule

// File: sv/jpd_mul.sv
module jpd_mul import jpd_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                 clk_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  output logic signed [DW-1:0] p_o
);

  // Q16.16 product, truncated toward zero, saturated to DW bits.
  // Magnitudes are split in halves so each partial product stays narrow.
  localparam int H  = (DW + 1) / 2;
  localparam int MW = 2 * H;
  localparam int PW = 4 * H;

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW:0] a_ext, b_ext, a_mag, b_mag;
  logic [MW-1:0]      ua_d, ub_d;
  logic [MW-1:0]      ua_q, ub_q;
  logic               neg1_q, neg2_q;
  logic [MW-1:0]      pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [PW-1:0]      sum, mag;
  logic [PW-1:0]      lim;
  logic [DW-1:0]      p_d;

  // Take magnitudes and the result sign
  always_comb begin
    a_ext = (DW+1)'(a_i);
    b_ext = (DW+1)'(b_i);
    a_mag = a_i[DW-1] ? -a_ext : a_ext;
    b_mag = b_i[DW-1] ? -b_ext : b_ext;
    ua_d  = MW'(a_mag[DW-1:0]);
    ub_d  = MW'(b_mag[DW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    ua_q   <= ua_d;
    ub_q   <= ub_d;
    neg1_q <= a_i[DW-1] ^ b_i[DW-1];
  end

  // Form the four partial products
  always_ff @(posedge clk_i) begin
    pp_hh_q <= MW'(ua_q[MW-1:H]) * MW'(ub_q[MW-1:H]);
    pp_hl_q <= MW'(ua_q[MW-1:H]) * MW'(ub_q[H-1:0]);
    pp_lh_q <= MW'(ua_q[H-1:0])  * MW'(ub_q[MW-1:H]);
    pp_ll_q <= MW'(ua_q[H-1:0])  * MW'(ub_q[H-1:0]);
    neg2_q  <= neg1_q;
  end

  // Sum, drop the fraction bits, saturate and restore the sign
  always_comb begin
    sum = (PW'(pp_hh_q) << MW) + (PW'(pp_hl_q) << H) + (PW'(pp_lh_q) << H)
        + PW'(pp_ll_q);
    mag = sum >> 16;
    lim = PW'(1'b1) << (DW - 1);
    priority if (neg2_q && (mag >= lim)) begin
      p_d = SMIN;
    end else if (neg2_q) begin
      p_d = {DW{1'b0}} - mag[DW-1:0];
    end else if (mag >= lim) begin
      p_d = SMAX;
    end else begin
      p_d = mag[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end

endmodule

// File: sv/jpd_front.sv
module jpd_front import jpd_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                    clk_i,
  input  logic signed [IN_W-1:0]  desired_position_i,
  input  logic signed [IN_W-1:0]  desired_velocity_i,
  input  logic signed [IN_W-1:0]  desired_acceleration_i,
  input  logic signed [IN_W-1:0]  measured_position_i,
  input  logic signed [IN_W-1:0]  measured_velocity_i,
  input  logic signed [IN_W-1:0]  position_min_i,
  input  logic signed [IN_W-1:0]  position_max_i,
  input  logic [CFG_W-1:0]        speed_limit_i,
  output logic signed [DW-1:0]    dacc_o,
  output logic signed [DW-1:0]    mvel_o,
  output logic signed [DW-1:0]    dvel_err_o,
  output logic signed [DW-1:0]    dpos_err_o,
  output logic signed [DW-1:0]    pmin_rel_o,
  output logic signed [DW-1:0]    pmax_rel_o,
  output logic signed [DW-1:0]    lovel_arg_o,
  output logic signed [DW-1:0]    hivel_arg_o
);

  localparam int WW = ((DW > IN_W) ? DW : IN_W) + 2;

  function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      sat_w = hi[DW-1:0];
    end else if (x < lo) begin
      sat_w = lo[DW-1:0];
    end else begin
      sat_w = x[DW-1:0];
    end
  endfunction

  logic signed [DW-1:0] dpos, dvel, dacc, mpos, mvel, pmin, pmax, vlim, vsum;

  // Bring inputs to the working width
  always_comb begin
    dpos = sat_w(WW'(desired_position_i));
    dvel = sat_w(WW'(desired_velocity_i));
    dacc = sat_w(WW'(desired_acceleration_i));
    mpos = sat_w(WW'(measured_position_i));
    mvel = sat_w(WW'(measured_velocity_i));
    pmin = sat_w(WW'(position_min_i));
    pmax = sat_w(WW'(position_max_i));
    vlim = sat_w(WW'($signed({1'b0, speed_limit_i})));
    vsum = sat_w(WW'(vlim) + WW'(mvel));
  end

  // Register errors and the multiplier operands
  always_ff @(posedge clk_i) begin
    dacc_o      <= dacc;
    mvel_o      <= mvel;
    dvel_err_o  <= sat_w(WW'(dvel) - WW'(mvel));
    dpos_err_o  <= sat_w(WW'(dpos) - WW'(mpos));
    pmin_rel_o  <= sat_w(WW'(pmin) - WW'(mpos));
    pmax_rel_o  <= sat_w(WW'(pmax) - WW'(mpos));
    lovel_arg_o <= sat_w(-WW'(vsum));
    hivel_arg_o <= sat_w(WW'(vlim) - WW'(mvel));
  end

endmodule

// File: sv/jpd_clamp.sv
module jpd_clamp import jpd_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                    clk_i,
  input  logic signed [DW-1:0]    cmd_i,
  input  logic signed [DW-1:0]    fallback_i,
  input  logic signed [DW-1:0]    lo_pos_i,
  input  logic signed [DW-1:0]    lo_vel_i,
  input  logic signed [DW-1:0]    hi_pos_i,
  input  logic signed [DW-1:0]    hi_vel_i,
  input  logic signed [DW-1:0]    margin_i,
  output logic signed [OUT_W-1:0] accel_command_o,
  output logic signed [OUT_W-1:0] accel_lower_o,
  output logic signed [OUT_W-1:0] accel_upper_o,
  output logic [1:0]              status_o
);

  localparam int WW = ((DW > OUT_W) ? DW : OUT_W) + 2;

  function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      sat_w = hi[DW-1:0];
    end else if (x < lo) begin
      sat_w = lo[DW-1:0];
    end else begin
      sat_w = x[DW-1:0];
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_o(input logic signed [DW-1:0] v);
    logic signed [WW-1:0] x;
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    x  = WW'(v);
    hi = {{(WW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      sat_o = hi[OUT_W-1:0];
    end else if (x < lo) begin
      sat_o = lo[OUT_W-1:0];
    end else begin
      sat_o = x[OUT_W-1:0];
    end
  endfunction

  logic signed [DW-1:0] lower_q, upper_q, cmd_q, fb_q;
  logic signed [DW-1:0] cmd_d;
  jpd_status_e          stat_d;

  // Pick the tighter bound on each side
  always_ff @(posedge clk_i) begin
    lower_q <= (lo_pos_i > lo_vel_i) ? lo_pos_i : lo_vel_i;
    upper_q <= (hi_pos_i < hi_vel_i) ? hi_pos_i : hi_vel_i;
    cmd_q   <= cmd_i;
    fb_q    <= fallback_i;
  end

  // Fall back on inverted or touching bounds, else pull a command at or past a bound inside by the margin
  always_comb begin
    priority if (lower_q >= upper_q) begin
      cmd_d  = fb_q;
      stat_d = STAT_FALLBACK;
    end else if (cmd_q <= lower_q) begin
      cmd_d  = sat_w(WW'(lower_q) + WW'(margin_i));
      stat_d = STAT_LOW;
    end else if (cmd_q >= upper_q) begin
      cmd_d  = sat_w(WW'(upper_q) - WW'(margin_i));
      stat_d = STAT_HIGH;
    end else begin
      cmd_d  = cmd_q;
      stat_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    accel_command_o <= sat_o(cmd_d);
    accel_lower_o   <= sat_o(lower_q);
    accel_upper_o   <= sat_o(upper_q);
    status_o        <= stat_d;
  end

endmodule
